FILE: rtl/bptc_pkg.sv
// Shared types and constants for the barometer compensation pipeline.
package bptc_pkg;

  localparam int NUM_STAGES = 9;

  localparam int CFG_IDX_W  = 3;
  localparam int COEF_W     = 16;
  localparam int RAW_W      = 24;
  localparam int TEMP_OUT_W = 15;
  localparam int PRES_OUT_W = 17;

  localparam int DT_W    = 25;
  localparam int PROD1_W = 42;
  localparam int SQD_W   = 50;
  localparam int DIFF_W  = 19;
  localparam int TW      = 20;
  localparam int SQ_W    = 40;
  localparam int OFF_W   = 40;
  localparam int SPLIT_W = 20;
  localparam int PPLO_W  = 44;
  localparam int PPHI_W  = 45;
  localparam int PROD_W  = 66;
  localparam int Q_W     = 46;

  localparam int TEMP_REF   = 2000;
  localparam int TEMP_VCOLD = -1500;
  localparam int VCOLD_OFS  = TEMP_REF - TEMP_VCOLD;
  localparam int TEMP_MIN   = -4000;
  localparam int TEMP_MAX   = 8500;
  localparam int PRES_MIN   = 1000;
  localparam int PRES_MAX   = 120000;

  localparam int C5_SHIFT   = 8;
  localparam int C2_SHIFT   = 16;
  localparam int C1_SHIFT   = 15;
  localparam int TEMP_SHIFT = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int T2_SHIFT   = 31;
  localparam int P_SHIFT_A  = 21;
  localparam int P_SHIFT_B  = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_PRES_SENS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_REF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TC   = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } coef_t;

  typedef struct packed {
    logic signed [OFF_W-1:0]      off1;
    logic signed [OFF_W-1:0]      sens1;
    logic signed [OFF_W-1:0]      off2;
    logic signed [OFF_W-1:0]      sens2;
    logic [RAW_W-1:0]             d1;
    logic signed [TEMP_OUT_W-1:0] temp;
    logic                         tflag;
  } front_t;

endpackage

FILE: rtl/barometer_temp_pressure_compensation.sv
// Barometric sensor compensation top level: nine-stage pipeline with second-order correction.
// Takes raw pressure and temperature transactions and returns the compensated temperature
// (0.01 C) and pressure (0.01 mbar), both saturated to the sensor range with out_of_range
// flagging a clamp. The rate is one transaction per cycle while the output is ready, set by
// the nine registered stages that each advance independently; a stalled output fills the
// bubbles first and then holds the input. The user must write calibration words through
// cfg_we_i/cfg_addr_i/cfg_wdata_i only while no transaction is in flight; the block does not enforce it.
module barometer_temp_pressure_compensation import bptc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_addr_i,
  input  logic [COEF_W-1:0]            cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [RAW_W-1:0]             raw_pressure_i,
  input  logic [RAW_W-1:0]             raw_temperature_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [TEMP_OUT_W-1:0] temperature_centi_o,
  output logic [PRES_OUT_W-1:0]        pressure_centi_mbar_o,
  output logic                         out_of_range_o
);

  coef_t                 coef;
  logic [NUM_STAGES-1:0] load;
  front_t                front;

  bptc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  bptc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .load_o      (load)
  );

  bptc_front u_front (
    .clk_i             (clk_i),
    .load_i            (load),
    .coef_i            (coef),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .front_o           (front)
  );

  bptc_back u_back (
    .clk_i                 (clk_i),
    .load_i                (load),
    .front_i               (front),
    .temperature_centi_o   (temperature_centi_o),
    .pressure_centi_mbar_o (pressure_centi_mbar_o),
    .out_of_range_o        (out_of_range_o)
  );

endmodule

FILE: rtl/bptc_cfg.sv
// Calibration coefficient registers written through the configuration port.
module bptc_cfg import bptc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [COEF_W-1:0]    cfg_wdata_i,
  output coef_t                coef_o
);

  coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_PRES_SENS: coef_q.c1 <= cfg_wdata_i;
        CFG_PRES_OFF:  coef_q.c2 <= cfg_wdata_i;
        CFG_SENS_TC:   coef_q.c3 <= cfg_wdata_i;
        CFG_OFF_TC:    coef_q.c4 <= cfg_wdata_i;
        CFG_TEMP_REF:  coef_q.c5 <= cfg_wdata_i;
        CFG_TEMP_TC:   coef_q.c6 <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

FILE: rtl/bptc_ctrl.sv
// Per-stage valid bits and load enables of the compensation pipeline.
module bptc_ctrl import bptc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NUM_STAGES-1:0] load_o
);

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] load;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    load[NUM_STAGES-1] = ~valid_q[NUM_STAGES-1] | out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = ~valid_q[k] | load[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign load_o      = load;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0])
    else $error("accepted transaction missing from first stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled while pipeline has a bubble");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("ready did not propagate to input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NUM_STAGES-2] && !out_valid_o) |=> out_valid_o)
    else $error("transaction lost before output stage");
`endif

endmodule

FILE: rtl/bptc_front.sv
// Temperature path: dT, first and second order terms, clamped temperature.
module bptc_front import bptc_pkg::*; (
  input  logic                  clk_i,
  input  logic [NUM_STAGES-1:0] load_i,
  input  coef_t                 coef_i,
  input  logic [RAW_W-1:0]      raw_pressure_i,
  input  logic [RAW_W-1:0]      raw_temperature_i,
  output front_t                front_o
);

  // stage 0
  logic signed [DT_W-1:0]    dt_d, dt_q;
  logic [RAW_W-1:0]          d1_s0_q;
  // stage 1
  logic signed [PROD1_W-1:0] pt_d, pt_q, poff_d, poff_q, psens_d, psens_q;
  logic signed [SQD_W-1:0]   pdd_d, pdd_q;
  logic [RAW_W-1:0]          d1_s1_q;
  // stage 2
  logic signed [PROD1_W-1:0] pt_sh, poff_sh, psens_sh;
  logic signed [SQD_W-1:0]   pdd_sh;
  logic signed [DIFF_W-1:0]  diff_d, diff_q;
  logic signed [TW-1:0]      temp_d, temp_q, tp_d, tp_q, t2_d, t2_q;
  logic signed [OFF_W-1:0]   off1_d, off1_s2_q, sens1_d, sens1_s2_q;
  logic [RAW_W-1:0]          d1_s2_q;
  // stage 3
  logic signed [SQ_W-1:0]    low_d, low_q, vlow_d, vlow_q;
  logic signed [TW-1:0]      traw_d, traw_q;
  logic                      cold_q, vcold_q;
  logic signed [OFF_W-1:0]   off1_s3_q, sens1_s3_q;
  logic [RAW_W-1:0]          d1_s3_q;
  // stage 4
  logic signed [SQ_W-1:0]    low5, vlow7, vlow11;
  logic signed [OFF_W-1:0]   off2_d, sens2_d;
  logic signed [TEMP_OUT_W-1:0] tsat_d;
  logic                      tflag_d;
  front_t                    front_q;

  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed(DT_W'({coef_i.c5, C5_SHIFT'(0)}));

  assign pt_d    = PROD1_W'(dt_q) * $signed(PROD1_W'(coef_i.c6));
  assign poff_d  = PROD1_W'(dt_q) * $signed(PROD1_W'(coef_i.c4));
  assign psens_d = PROD1_W'(dt_q) * $signed(PROD1_W'(coef_i.c3));
  assign pdd_d   = SQD_W'(dt_q) * SQD_W'(dt_q);

  assign pt_sh    = pt_q >>> TEMP_SHIFT;
  assign poff_sh  = poff_q >>> OFF_SHIFT;
  assign psens_sh = psens_q >>> SENS_SHIFT;
  assign pdd_sh   = pdd_q >>> T2_SHIFT;
  assign diff_d   = DIFF_W'(pt_sh);
  assign temp_d   = TW'(diff_d) + TW'(TEMP_REF);
  assign tp_d     = TW'(diff_d) + TW'(VCOLD_OFS);
  assign t2_d     = TW'(pdd_sh);
  assign off1_d   = OFF_W'(poff_sh) + $signed(OFF_W'({coef_i.c2, C2_SHIFT'(0)}));
  assign sens1_d  = OFF_W'(psens_sh) + $signed(OFF_W'({coef_i.c1, C1_SHIFT'(0)}));

  assign low_d  = SQ_W'(diff_q) * SQ_W'(diff_q);
  assign vlow_d = SQ_W'(tp_q) * SQ_W'(tp_q);
  assign traw_d = diff_q[DIFF_W-1] ? temp_q - t2_q : temp_q;

  always_comb begin
    low5    = low_q + (low_q <<< 2);
    vlow7   = (vlow_q <<< 3) - vlow_q;
    vlow11  = (vlow_q <<< 3) + (vlow_q <<< 1) + vlow_q;
    off2_d  = '0;
    sens2_d = '0;
    if (cold_q) begin
      off2_d  = OFF_W'(low5 >>> 1);
      sens2_d = OFF_W'(low5 >>> 2);
      if (vcold_q) begin
        off2_d  = off2_d + OFF_W'(vlow7);
        sens2_d = sens2_d + OFF_W'(vlow11 >>> 1);
      end
    end
    tflag_d = 1'b0;
    tsat_d  = TEMP_OUT_W'(traw_q);
    if (traw_q < TW'(TEMP_MIN)) begin
      tflag_d = 1'b1;
      tsat_d  = TEMP_OUT_W'(TEMP_MIN);
    end else if (traw_q > TW'(TEMP_MAX)) begin
      tflag_d = 1'b1;
      tsat_d  = TEMP_OUT_W'(TEMP_MAX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      dt_q    <= dt_d;
      d1_s0_q <= raw_pressure_i;
    end
    if (load_i[1]) begin
      pt_q    <= pt_d;
      poff_q  <= poff_d;
      psens_q <= psens_d;
      pdd_q   <= pdd_d;
      d1_s1_q <= d1_s0_q;
    end
    if (load_i[2]) begin
      diff_q     <= diff_d;
      temp_q     <= temp_d;
      tp_q       <= tp_d;
      t2_q       <= t2_d;
      off1_s2_q  <= off1_d;
      sens1_s2_q <= sens1_d;
      d1_s2_q    <= d1_s1_q;
    end
    if (load_i[3]) begin
      low_q      <= low_d;
      vlow_q     <= vlow_d;
      traw_q     <= traw_d;
      cold_q     <= diff_q[DIFF_W-1];
      vcold_q    <= tp_q[TW-1];
      off1_s3_q  <= off1_s2_q;
      sens1_s3_q <= sens1_s2_q;
      d1_s3_q    <= d1_s2_q;
    end
    if (load_i[4]) begin
      front_q.off1  <= off1_s3_q;
      front_q.sens1 <= sens1_s3_q;
      front_q.off2  <= off2_d;
      front_q.sens2 <= sens2_d;
      front_q.d1    <= d1_s3_q;
      front_q.temp  <= tsat_d;
      front_q.tflag <= tflag_d;
    end
  end

  assign front_o = front_q;

endmodule

FILE: rtl/bptc_back.sv
// Pressure path: corrected offset and sensitivity, split product, clamp.
module bptc_back import bptc_pkg::*; (
  input  logic                         clk_i,
  input  logic [NUM_STAGES-1:0]        load_i,
  input  front_t                       front_i,
  output logic signed [TEMP_OUT_W-1:0] temperature_centi_o,
  output logic [PRES_OUT_W-1:0]        pressure_centi_mbar_o,
  output logic                         out_of_range_o
);

  // stage 5
  logic signed [OFF_W-1:0]      off_d, off_s5_q, sens_d, sens_q;
  logic [RAW_W-1:0]             d1_q;
  logic signed [TEMP_OUT_W-1:0] temp_s5_q, temp_s6_q, temp_s7_q;
  logic                         tflag_s5_q, tflag_s6_q, tflag_s7_q;
  // stage 6
  logic [PPLO_W-1:0]            pplo_d, pplo_q;
  logic signed [PPHI_W-1:0]     pphi_d, pphi_q;
  logic signed [OFF_W-1:0]      off_s6_q, off_s7_q;
  // stage 7
  logic signed [PROD_W-1:0]     prod_d, prod_q, prod_sh;
  // stage 8
  logic signed [Q_W-1:0]        q_val, pres_w;
  logic [PRES_OUT_W-1:0]        pres_d, pres_q;
  logic                         pflag_d;
  logic signed [TEMP_OUT_W-1:0] temp_q;
  logic                         oor_q;

  assign off_d  = front_i.off1 - front_i.off2;
  assign sens_d = front_i.sens1 - front_i.sens2;

  assign pplo_d = PPLO_W'(d1_q) * PPLO_W'(sens_q[SPLIT_W-1:0]);
  assign pphi_d = $signed(PPHI_W'(d1_q)) * PPHI_W'($signed(sens_q[OFF_W-1:SPLIT_W]));

  assign prod_d  = (PROD_W'(pphi_q) <<< SPLIT_W) + $signed(PROD_W'(pplo_q));
  assign prod_sh = prod_q >>> P_SHIFT_A;
  assign q_val   = Q_W'(prod_sh) - Q_W'(off_s7_q);
  assign pres_w  = q_val >>> P_SHIFT_B;

  always_comb begin
    pflag_d = 1'b0;
    pres_d  = PRES_OUT_W'(pres_w);
    if (pres_w < Q_W'(PRES_MIN)) begin
      pflag_d = 1'b1;
      pres_d  = PRES_OUT_W'(PRES_MIN);
    end else if (pres_w > Q_W'(PRES_MAX)) begin
      pflag_d = 1'b1;
      pres_d  = PRES_OUT_W'(PRES_MAX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[5]) begin
      off_s5_q   <= off_d;
      sens_q     <= sens_d;
      d1_q       <= front_i.d1;
      temp_s5_q  <= front_i.temp;
      tflag_s5_q <= front_i.tflag;
    end
    if (load_i[6]) begin
      pplo_q     <= pplo_d;
      pphi_q     <= pphi_d;
      off_s6_q   <= off_s5_q;
      temp_s6_q  <= temp_s5_q;
      tflag_s6_q <= tflag_s5_q;
    end
    if (load_i[7]) begin
      prod_q     <= prod_d;
      off_s7_q   <= off_s6_q;
      temp_s7_q  <= temp_s6_q;
      tflag_s7_q <= tflag_s6_q;
    end
    if (load_i[8]) begin
      pres_q <= pres_d;
      temp_q <= temp_s7_q;
      oor_q  <= tflag_s7_q | pflag_d;
    end
  end

  assign temperature_centi_o   = temp_q;
  assign pressure_centi_mbar_o = pres_q;
  assign out_of_range_o        = oor_q;

endmodule

FILE: verif/barometer_temp_pressure_compensation_tb.sv
// Self-checking testbench for the barometer temperature and pressure compensation pipeline.
`timescale 1ns / 100ps

module barometer_temp_pressure_compensation_tb;
  import bptc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam int STALL_LIMIT  = 4000;
  localparam int SEGMENTS     = 12;
  localparam int SEG_READINGS = 100;
  localparam int RAW_MAX      = (1 << RAW_W) - 1;

  localparam coef_t TYPICAL_CAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                    c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
  localparam coef_t EDGE_CAL    = '{c1: 16'hFFFF, c2: 16'h0000, c3: 16'h0000,
                                    c4: 16'hFFFF, c5: 16'h0000, c6: 16'hFFFF};

  typedef struct packed {
    logic signed [TEMP_OUT_W-1:0] temp;
    logic [PRES_OUT_W-1:0]        pres;
    logic                         sat;
  } comp_result_t;

  class comp_scoreboard;
    coef_t        cal;
    comp_result_t expected_q[$];
    int unsigned  failures;
    int unsigned  checked;
    int unsigned  cold_cnt;
    int unsigned  vcold_cnt;
    int unsigned  sat_cnt;

    function new();
      cal       = '0;
      failures  = 0;
      checked   = 0;
      cold_cnt  = 0;
      vcold_cnt = 0;
      sat_cnt   = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        CFG_PRES_SENS: cal.c1 = val;
        CFG_PRES_OFF:  cal.c2 = val;
        CFG_SENS_TC:   cal.c3 = val;
        CFG_OFF_TC:    cal.c4 = val;
        CFG_TEMP_REF:  cal.c5 = val;
        CFG_TEMP_TC:   cal.c6 = val;
        default: ;
      endcase
    endfunction

    function comp_result_t compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
      logic signed [127:0] d1s, dt, c1, c2, c3, c4, c5, c6;
      logic signed [127:0] temp, off, sens, t_out, t2, low, vlow, off2, sens2, pres;
      comp_result_t r;
      d1s = d1;
      dt  = d2;
      c1  = cal.c1;
      c2  = cal.c2;
      c3  = cal.c3;
      c4  = cal.c4;
      c5  = cal.c5;
      c6  = cal.c6;
      dt    = dt - (c5 <<< C5_SHIFT);
      temp  = TEMP_REF + ((dt * c6) >>> TEMP_SHIFT);
      off   = (c2 <<< C2_SHIFT) + ((c4 * dt) >>> OFF_SHIFT);
      sens  = (c1 <<< C1_SHIFT) + ((c3 * dt) >>> SENS_SHIFT);
      t_out = temp;
      if (temp < TEMP_REF) begin
        cold_cnt++;
        t2    = (dt * dt) >>> T2_SHIFT;
        low   = (temp - TEMP_REF) * (temp - TEMP_REF);
        off2  = (5 * low) >>> 1;
        sens2 = (5 * low) >>> 2;
        if (temp < TEMP_VCOLD) begin
          vcold_cnt++;
          vlow  = (temp - TEMP_VCOLD) * (temp - TEMP_VCOLD);
          off2  = off2 + 7 * vlow;
          sens2 = sens2 + ((11 * vlow) >>> 1);
        end
        off   = off - off2;
        sens  = sens - sens2;
        t_out = temp - t2;
      end
      pres  = (((d1s * sens) >>> P_SHIFT_A) - off) >>> P_SHIFT_B;
      r.sat = 1'b0;
      if (t_out < TEMP_MIN) begin
        t_out = TEMP_MIN;
        r.sat = 1'b1;
      end else if (t_out > TEMP_MAX) begin
        t_out = TEMP_MAX;
        r.sat = 1'b1;
      end
      if (pres < PRES_MIN) begin
        pres  = PRES_MIN;
        r.sat = 1'b1;
      end else if (pres > PRES_MAX) begin
        pres  = PRES_MAX;
        r.sat = 1'b1;
      end
      if (r.sat) sat_cnt++;
      r.temp = t_out[TEMP_OUT_W-1:0];
      r.pres = pres[PRES_OUT_W-1:0];
      return r;
    endfunction

    function void note_reading(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
      expected_q.push_back(compensate(d1, d2));
    endfunction

    function void check_result(logic signed [TEMP_OUT_W-1:0] temp,
                               logic [PRES_OUT_W-1:0] pres, logic sat);
      comp_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result temp %0d pres %0d flag %0b",
                   $realtime, temp, pres, sat);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (temp !== want.temp || pres !== want.pres || sat !== want.sat) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch temp exp %0d got %0d, pres exp %0d got %0d, flag exp %0b got %0b",
                   $realtime, want.temp, temp, want.pres, pres, want.sat, sat);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_addr_i = CFG_PRES_SENS;
  logic [COEF_W-1:0]            cfg_wdata_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [RAW_W-1:0]             raw_pressure_i = '0;
  logic [RAW_W-1:0]             raw_temperature_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic signed [TEMP_OUT_W-1:0] temperature_centi_o;
  logic [PRES_OUT_W-1:0]        pressure_centi_mbar_o;
  logic                         out_of_range_o;

  comp_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    readings_sent = 0;
  int unsigned    cal_sets = 0;
  int unsigned    idle_cycles = 0;

  barometer_temp_pressure_compensation DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_addr_i            (cfg_addr_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .raw_pressure_i        (raw_pressure_i),
    .raw_temperature_i     (raw_temperature_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .temperature_centi_o   (temperature_centi_o),
    .pressure_centi_mbar_o (pressure_centi_mbar_o),
    .out_of_range_o        (out_of_range_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(temperature_centi_o, pressure_centi_mbar_o, out_of_range_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= d1;
    raw_temperature_i <= d2;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_reading(d1, d2);
    readings_sent++;
  endtask

  // drop valid and hold until the pipeline is empty
  task automatic finish_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    sb.set_coef(idx, val);
  endtask

  task automatic load_calibration(input coef_t cal);
    write_reg(CFG_PRES_SENS, cal.c1);
    write_reg(CFG_PRES_OFF, cal.c2);
    write_reg(CFG_SENS_TC, cal.c3);
    write_reg(CFG_OFF_TC, cal.c4);
    write_reg(CFG_TEMP_REF, cal.c5);
    write_reg(CFG_TEMP_TC, cal.c6);
    write_reg(CFG_UNUSED_LO, COEF_W'($urandom));
    write_reg(CFG_UNUSED_HI, COEF_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cal_sets++;
  endtask

  initial begin : stimulus
    coef_t            cal;
    logic [5:0]       ext;
    int               ref_raw;
    int               t_raw;
    int unsigned      pick;
    logic [RAW_W-1:0] d1, d2;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // calibration still at reset
    send_reading(24'd0, 24'd0);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'hAAAAAA, 24'h555555);
    finish_burst();

    // reference point, cold and very-cold thresholds
    load_calibration(TYPICAL_CAL);
    send_reading(24'd8500000, 24'd8566784);
    send_reading(24'd8500000, 24'd8566783);
    send_reading(24'd8500000, 24'd7529764);
    send_reading(24'd8500000, 24'd7529763);
    send_reading(24'd8500000, 24'd0);
    send_reading(24'd8500000, 24'hFFFFFF);
    send_reading(24'd0, 24'd8566784);
    send_reading(24'hFFFFFF, 24'd8566784);
    send_reading(24'd6000000, 24'd8000000);
    finish_burst();

    load_calibration(coef_t'('1));
    send_reading(24'd0, 24'd0);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'd0);
    send_reading(24'd0, 24'hFFFFFF);
    finish_burst();

    load_calibration(EDGE_CAL);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'd0);
    finish_burst();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 3)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg % 4)
        1: cal = {$urandom, $urandom, $urandom};
        2: begin
          ext = 6'($urandom);
          cal = {{16{ext[5]}}, {16{ext[4]}}, {16{ext[3]}},
                 {16{ext[2]}}, {16{ext[1]}}, {16{ext[0]}}};
        end
        default: begin
          cal    = TYPICAL_CAL;
          cal.c1 = cal.c1 + COEF_W'($urandom_range(0, 4000)) - 16'd2000;
          cal.c2 = cal.c2 + COEF_W'($urandom_range(0, 4000)) - 16'd2000;
          cal.c3 = cal.c3 + COEF_W'($urandom_range(0, 4000)) - 16'd2000;
          cal.c4 = cal.c4 + COEF_W'($urandom_range(0, 4000)) - 16'd2000;
          cal.c5 = cal.c5 + COEF_W'($urandom_range(0, 4000)) - 16'd2000;
          cal.c6 = cal.c6 + COEF_W'($urandom_range(0, 4000)) - 16'd2000;
        end
      endcase
      load_calibration(cal);
      ref_raw = int'({cal.c5, 8'h00});

      for (int i = 0; i < SEG_READINGS; i++) begin
        if (seg % 3 == 0 && i == SEG_READINGS / 2) finish_burst();
        pick = $urandom_range(0, 7);
        if (pick < 4)
          d1 = RAW_W'($urandom);
        else if (pick < 7)
          d1 = RAW_W'($urandom_range(4000000, 10000000));
        else
          d1 = $urandom_range(0, 1) ? RAW_W'(RAW_MAX) : '0;
        pick = $urandom_range(0, 7);
        if (pick < 2) begin
          d2 = RAW_W'($urandom);
        end else if (pick < 7) begin
          t_raw = ref_raw + int'($urandom_range(0, 5000000)) - 3000000;
          if (t_raw < 0) t_raw = 0;
          if (t_raw > RAW_MAX) t_raw = RAW_MAX;
          d2 = RAW_W'(t_raw);
        end else begin
          d2 = $urandom_range(0, 1) ? RAW_W'(RAW_MAX) : '0;
        end
        send_reading(d1, d2);
      end
      finish_burst();
    end

    recv_idle_pct = 0;
    repeat (4 * NUM_STAGES) @(posedge clk_i);

    $display("Summary: %0d readings under %0d calibration sets, %0d results checked",
             readings_sent, cal_sets, sb.checked);
    $display("Summary: %0d below 20 C, %0d below -15 C, %0d saturated",
             sb.cold_cnt, sb.vcold_cnt, sb.sat_cnt);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
